// ===== src/mi3_pkg.sv =====
`timescale 1ns / 1ps
package mi3_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int FRAC_BITS = 16;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] m11;
    logic signed [DATA_WIDTH-1:0] m12;
    logic signed [DATA_WIDTH-1:0] m13;
    logic signed [DATA_WIDTH-1:0] m21;
    logic signed [DATA_WIDTH-1:0] m22;
    logic signed [DATA_WIDTH-1:0] m23;
    logic signed [DATA_WIDTH-1:0] m31;
    logic signed [DATA_WIDTH-1:0] m32;
    logic signed [DATA_WIDTH-1:0] m33;
  } mi3_in_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] inv11;
    logic signed [DATA_WIDTH-1:0] inv12;
    logic signed [DATA_WIDTH-1:0] inv13;
    logic signed [DATA_WIDTH-1:0] inv21;
    logic signed [DATA_WIDTH-1:0] inv22;
    logic signed [DATA_WIDTH-1:0] inv23;
    logic signed [DATA_WIDTH-1:0] inv31;
    logic signed [DATA_WIDTH-1:0] inv32;
    logic signed [DATA_WIDTH-1:0] inv33;
    logic                         singular;
  } mi3_out_t;

endpackage

// ===== src/mi3_div_lane.sv =====
`timescale 1ns / 1ps
// Pipelined restoring divider: one quotient bit per stage, with saturation at the end.
// Magnitudes: numerator below 2^(2*DW + 2*FB), denominator nonzero.
module mi3_div_lane #(
  parameter int NumW = 96,
  parameter int DenW = 98,
  parameter int DW = 32,
  parameter int QW = 40
) (
  input  logic            clk_i,
  input  logic            en_i,
  input  logic [NumW-1:0] num_i,
  input  logic [DenW-1:0] den_i,
  input  logic            neg_i,
  output logic [DW-1:0]   q_o
);

  logic [NumW-1:0] num_q [NumW];
  logic [DenW-1:0] den_q [NumW];
  logic [DenW:0]   rem_q [NumW];
  logic [QW-1:0]   quo_q [NumW];
  logic            big_q [NumW];
  logic            neg_q [NumW];

  for (genvar s = 0; s < NumW; s++) begin : g_stage
    logic [NumW-1:0] num_in;
    logic [DenW-1:0] den_in;
    logic [DenW:0]   rem_in;
    logic [QW-1:0]   quo_in;
    logic            big_in;
    logic            neg_in;
    logic [DenW:0]   trial;
    logic            ge;
    if (s == 0) begin : g_head
      assign num_in = num_i;
      assign den_in = den_i;
      assign rem_in = '0;
      assign quo_in = '0;
      assign big_in = 1'b0;
      assign neg_in = neg_i;
    end else begin : g_body
      assign num_in = num_q[s-1];
      assign den_in = den_q[s-1];
      assign rem_in = rem_q[s-1];
      assign quo_in = quo_q[s-1];
      assign big_in = big_q[s-1];
      assign neg_in = neg_q[s-1];
    end
    assign trial = {rem_in[DenW-1:0], num_in[NumW-1-s]};
    assign ge = trial >= {1'b0, den_in};
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        num_q[s] <= num_in;
        den_q[s] <= den_in;
        neg_q[s] <= neg_in;
        rem_q[s] <= ge ? trial - {1'b0, den_in} : trial;
        quo_q[s] <= {quo_in[QW-2:0], ge};
        big_q[s] <= big_in | quo_in[QW-1];
      end
    end
  end

  logic [QW-1:0] mag;
  logic [QW-1:0] lim;
  logic [QW-1:0] sat;
  assign mag = quo_q[NumW-1];
  assign lim = neg_q[NumW-1] ? (QW'(1) << (DW-1)) : ((QW'(1) << (DW-1)) - QW'(1));
  assign sat = (big_q[NumW-1] || mag > lim) ? lim : mag;
  assign q_o = neg_q[NumW-1] ? DW'(-sat) : DW'(sat);

endmodule

// ===== src/matrix3x3_inverse.sv =====
`timescale 1ns / 1ps
// 3x3 matrix inverse by adjugate over determinant, signed fixed point.
// Input channel in_valid_i/in_ready_o carries one matrix per item; output
// channel out_valid_o/out_ready_i carries the nine inverse entries and a
// singular flag. Nine divider lanes run side by side, one per entry.
// The product stage loads at the accepting edge; behind it come a cofactor
// stage, two determinant stages, a sign stage, then one quotient bit per
// divider stage, and out_valid_o rises as the last divider stage loads.
// Throughput is one item per cycle while the pipe is not stalled. The whole
// pipe advances together and stalls only when the output register is full
// and not taken; in_ready_o is low then. Reset clears all valid bits; no
// item is in flight afterward.
// A zero determinant gives all-zero entries with singular set.
module matrix3x3_inverse
  import mi3_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  mi3_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output mi3_out_t out_data_o
);

  localparam int DW = DATA_WIDTH;
  localparam int PW = 2 * DW + 1;
  localparam int DTW = 3 * DW + 3;
  localparam int NumW = PW + 2 * FRAC_BITS;
  localparam int QW = DW + 8;
  localparam int Lat = 4 + NumW;

  logic en;
  logic [Lat:0] vld_q;
  assign en = !vld_q[Lat] || out_ready_i;
  assign in_ready_o = en;
  assign out_valid_o = vld_q[Lat];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Lat-1:0], in_valid_i};
    end
  end
  // vld_q[0] unused as storage beyond shifting; bit 0 is the first stage.

  logic signed [DW-1:0] m [9];
  assign m[0] = in_data_i.m11;
  assign m[1] = in_data_i.m12;
  assign m[2] = in_data_i.m13;
  assign m[3] = in_data_i.m21;
  assign m[4] = in_data_i.m22;
  assign m[5] = in_data_i.m23;
  assign m[6] = in_data_i.m31;
  assign m[7] = in_data_i.m32;
  assign m[8] = in_data_i.m33;

  // Operand indexes a,b,c,d of each cofactor a*d - c*b.
  localparam int IA [9] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
  localparam int IB [9] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
  localparam int IC [9] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};
  localparam int ID [9] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};

  // Stage 1: products.
  logic signed [2*DW-1:0] pad_q [9];
  logic signed [2*DW-1:0] pcb_q [9];
  logic signed [DW-1:0]   row_q [3];
  // Stage 2: cofactors.
  logic signed [PW-1:0]   cof_q [9];
  logic signed [DW-1:0]   row2_q [3];
  // Stage 3: first-row entries times the low and high halves of their cofactors.
  logic signed [PW-1:0]   plo_q [3];
  logic signed [PW-1:0]   phi_q [3];
  logic signed [PW-1:0]   cof3_q [9];
  // Stage 4: first-row terms of the determinant.
  logic signed [DTW-1:0]  dt_q [3];
  logic signed [PW-1:0]   cof4_q [9];
  // Stage 5: signs and magnitudes.
  logic [NumW-1:0]        num_q [9];
  logic [DTW-1:0]         den_q;
  logic                   neg_q [9];
  logic                   sing_q [Lat:4];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 9; i++) begin
        pad_q[i] <= (2*DW)'(m[IA[i]]) * (2*DW)'(m[ID[i]]);
        pcb_q[i] <= (2*DW)'(m[IC[i]]) * (2*DW)'(m[IB[i]]);
        cof_q[i] <= PW'(pad_q[i]) - PW'(pcb_q[i]);
        cof3_q[i] <= cof_q[i];
        cof4_q[i] <= cof3_q[i];
      end
      for (int k = 0; k < 3; k++) begin
        row_q[k] <= m[k];
        row2_q[k] <= row_q[k];
        plo_q[k] <= PW'(row2_q[k]) * PW'($signed({1'b0, cof_q[3*k][DW-1:0]}));
        phi_q[k] <= PW'(row2_q[k]) * PW'($signed(cof_q[3*k][PW-1:DW]));
        dt_q[k] <= (DTW'(phi_q[k]) << DW) + DTW'(plo_q[k]);
      end
    end
  end

  logic signed [DTW-1:0] det;
  logic [DTW-1:0] det_mag;
  assign det = dt_q[0] + dt_q[1] + dt_q[2];
  assign det_mag = det[DTW-1] ? DTW'(-det) : DTW'(det);

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 9; i++) begin
        num_q[i] <= NumW'(cof4_q[i][PW-1] ? PW'(-cof4_q[i]) : PW'(cof4_q[i]))
                    << (2 * FRAC_BITS);
        neg_q[i] <= (cof4_q[i] != '0) && (cof4_q[i][PW-1] != det[DTW-1]);
      end
      den_q <= (det == '0) ? DTW'(1) : det_mag;
      sing_q[4] <= det == '0;
      for (int s = 5; s <= Lat; s++) sing_q[s] <= sing_q[s-1];
    end
  end

  logic [DW-1:0] q [9];
  for (genvar l = 0; l < 9; l++) begin : g_lane
    mi3_div_lane #(.NumW(NumW), .DenW(DTW), .DW(DW), .QW(QW)) u_div (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i (num_q[l]),
      .den_i (den_q),
      .neg_i (neg_q[l]),
      .q_o   (q[l])
    );
  end

  // Merge: zero all entries of a singular matrix.
  logic [DW-1:0] r [9];
  always_comb begin
    for (int i = 0; i < 9; i++) begin
      r[i] = sing_q[Lat] ? '0 : q[i];
    end
  end
  assign out_data_o.inv11 = r[0];
  assign out_data_o.inv12 = r[1];
  assign out_data_o.inv13 = r[2];
  assign out_data_o.inv21 = r[3];
  assign out_data_o.inv22 = r[4];
  assign out_data_o.inv23 = r[5];
  assign out_data_o.inv31 = r[6];
  assign out_data_o.inv32 = r[7];
  assign out_data_o.inv33 = r[8];
  assign out_data_o.singular = sing_q[Lat];

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o) else $error("pipe stalled with empty output");
  a_hold_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");
  a_singular_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.singular |-> out_data_o.inv11 == '0 &&
    out_data_o.inv22 == '0 && out_data_o.inv33 == '0)
    else $error("singular item with nonzero entries");

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
module tb
  import mi3_pkg::*;
;

  localparam int LATENCY = 5 + 2 * (32 + 16);
  localparam int N_RANDOM = 1530;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic signed [31:0] ONE = 32'sh0001_0000;
  localparam logic signed [31:0] QMAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] QMIN = 32'sh8000_0000;

  typedef logic signed [191:0] wide_t;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     in_valid_i = 1'b0;
  logic     in_ready_o;
  mi3_in_t  in_data_i = '0;
  logic     out_valid_o;
  logic     out_ready_i = 1'b0;
  mi3_out_t out_data_o;

  mi3_out_t inverse_q[$];
  int       errors = 0;
  int       cycles = 0;
  bit       feeding_done = 1'b0;

  matrix3x3_inverse u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Quotient of cofactor * 2^32 by the determinant, truncated and saturated.
  function automatic logic signed [31:0] scaled_entry(wide_t cof, wide_t det);
    wide_t num;
    logic [191:0] un, ud, uq, lim;
    bit neg;
    num = cof <<< 32;
    neg = (num < 0) != (det < 0);
    un = (num < 0) ? -num : num;
    ud = (det < 0) ? -det : det;
    uq = un / ud;
    lim = neg ? 192'h8000_0000 : 192'h7fff_ffff;
    if (uq > lim) uq = lim;
    return neg ? -uq[31:0] : uq[31:0];
  endfunction

  function automatic mi3_out_t invert_matrix(mi3_in_t m);
    wide_t a[9];
    wide_t cof[9];
    wide_t det;
    logic signed [31:0] o[9];
    mi3_out_t r;
    a[0] = m.m11; a[1] = m.m12; a[2] = m.m13;
    a[3] = m.m21; a[4] = m.m22; a[5] = m.m23;
    a[6] = m.m31; a[7] = m.m32; a[8] = m.m33;
    cof[0] = a[4] * a[8] - a[7] * a[5];
    cof[1] = a[2] * a[7] - a[8] * a[1];
    cof[2] = a[1] * a[5] - a[4] * a[2];
    cof[3] = a[5] * a[6] - a[8] * a[3];
    cof[4] = a[0] * a[8] - a[6] * a[2];
    cof[5] = a[2] * a[3] - a[5] * a[0];
    cof[6] = a[3] * a[7] - a[6] * a[4];
    cof[7] = a[1] * a[6] - a[7] * a[0];
    cof[8] = a[0] * a[4] - a[3] * a[1];
    det = a[0] * cof[0] + a[1] * cof[3] + a[2] * cof[6];
    r = '0;
    if (det == 0) begin
      r.singular = 1'b1;
      return r;
    end
    for (int i = 0; i < 9; i++) o[i] = scaled_entry(cof[i], det);
    r.inv11 = o[0]; r.inv12 = o[1]; r.inv13 = o[2];
    r.inv21 = o[3]; r.inv22 = o[4]; r.inv23 = o[5];
    r.inv31 = o[6]; r.inv32 = o[7]; r.inv33 = o[8];
    return r;
  endfunction

  function automatic mi3_in_t diag(logic signed [31:0] d1, logic signed [31:0] d2,
                                   logic signed [31:0] d3);
    mi3_in_t m;
    m = '0;
    m.m11 = d1; m.m22 = d2; m.m33 = d3;
    return m;
  endfunction

  function automatic mi3_out_t diag_inv(logic signed [31:0] d);
    mi3_out_t r;
    r = '0;
    r.inv11 = d; r.inv22 = d; r.inv33 = d;
    return r;
  endfunction

  function automatic logic signed [31:0] rand_entry(int kind);
    case (kind)
      0: return $urandom;
      1: return $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
      2: return $signed($urandom_range(0, 600)) - 300;
      default: begin
        case ($urandom_range(0, 4))
          0: return QMAX;
          1: return QMIN;
          2: return 0;
          3: return ONE;
          default: return -ONE;
        endcase
      end
    endcase
  endfunction

  function automatic mi3_in_t rand_matrix();
    mi3_in_t m;
    int kind;
    int shape;
    kind = $urandom_range(0, 3);
    m.m11 = rand_entry(kind); m.m12 = rand_entry(kind); m.m13 = rand_entry(kind);
    m.m21 = rand_entry(kind); m.m22 = rand_entry(kind); m.m23 = rand_entry(kind);
    m.m31 = rand_entry(kind); m.m32 = rand_entry(kind); m.m33 = rand_entry(kind);
    shape = $urandom_range(0, 9);
    if (shape == 0) begin
      // Repeated row makes the determinant exactly zero.
      m.m31 = m.m11; m.m32 = m.m12; m.m33 = m.m13;
    end else if (shape == 1) begin
      m.m21 = 0; m.m22 = 0; m.m23 = 0;
    end else if (shape <= 4) begin
      // Dominant diagonal keeps the inverse mostly in range.
      m.m11 = $signed($urandom_range(ONE, 32'h0040_0000)) * ($urandom_range(0, 1) ? 1 : -1);
      m.m22 = $signed($urandom_range(ONE, 32'h0040_0000));
      m.m33 = $signed($urandom_range(ONE, 32'h0040_0000)) * ($urandom_range(0, 1) ? 1 : -1);
      m.m12 = m.m12 >>> 4; m.m13 = m.m13 >>> 4; m.m21 = m.m21 >>> 4;
      m.m23 = m.m23 >>> 4; m.m31 = m.m31 >>> 4; m.m32 = m.m32 >>> 4;
    end
    return m;
  endfunction

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
    if (exp_v !== got_v) begin
      $error("%s: expected %h, got %h", name, exp_v, got_v);
      errors++;
    end
  endtask

  // Feeds matrices; the expected inverse is queued when the item is accepted.
  initial begin
    mi3_in_t  dir_in[$];
    bit       dir_typed[$];
    mi3_out_t dir_exp[$];
    mi3_in_t  m;
    mi3_out_t typed_r;
    int       gap;
    int       total;
    bit       busy_burst;

    typed_r = '0;
    typed_r.singular = 1'b1;
    dir_in.push_back('0); dir_typed.push_back(1); dir_exp.push_back(typed_r);
    dir_in.push_back({9{QMAX}}); dir_typed.push_back(1); dir_exp.push_back(typed_r);
    dir_in.push_back({9{QMIN}}); dir_typed.push_back(1); dir_exp.push_back(typed_r);
    dir_in.push_back(diag(ONE, ONE, ONE));
    dir_typed.push_back(1); dir_exp.push_back(diag_inv(ONE));
    dir_in.push_back(diag(-ONE, -ONE, -ONE));
    dir_typed.push_back(1); dir_exp.push_back(diag_inv(-ONE));
    // One-LSB diagonal: the inverse saturates high, or low when negated.
    dir_in.push_back(diag(1, 1, 1)); dir_typed.push_back(1); dir_exp.push_back(diag_inv(QMAX));
    dir_in.push_back(diag(-1, -1, -1));
    dir_typed.push_back(1); dir_exp.push_back(diag_inv(QMIN));
    dir_in.push_back(diag(ONE, 0, ONE)); dir_typed.push_back(1); dir_exp.push_back(typed_r);
    dir_in.push_back(diag(QMAX, QMAX, QMAX)); dir_typed.push_back(0); dir_exp.push_back('0);
    dir_in.push_back(diag(QMIN, QMIN, QMIN)); dir_typed.push_back(0); dir_exp.push_back('0);
    dir_in.push_back(diag(QMIN, QMAX, -ONE)); dir_typed.push_back(0); dir_exp.push_back('0);
    dir_in.push_back({QMAX, QMIN, QMAX, QMIN, QMAX, QMIN, QMAX, QMAX, QMIN});
    dir_typed.push_back(0); dir_exp.push_back('0);
    dir_in.push_back({ONE, ONE * 2, ONE * 3, 32'sd0, ONE, ONE * 4, ONE * 5, ONE * 6, 32'sd0});
    dir_typed.push_back(0); dir_exp.push_back('0);
    dir_in.push_back({32'sd0, ONE, 32'sd0, ONE, 32'sd0, 32'sd0, 32'sd0, 32'sd0, ONE});
    dir_typed.push_back(0); dir_exp.push_back('0);
    dir_in.push_back({ONE, ONE, ONE, ONE, ONE + 1, ONE, ONE, ONE, ONE + 2});
    dir_typed.push_back(0); dir_exp.push_back('0);
    dir_in.push_back({-ONE * 3, 32'sd7, 32'sd1, ONE >>> 2, QMAX, 32'sd0, 32'sd5, QMIN, ONE});
    dir_typed.push_back(0); dir_exp.push_back('0);

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    total = dir_in.size() + N_RANDOM;
    busy_burst = 1'b0;
    for (int n = 0; n < total; n++) begin
      if (n % 100 == 0) busy_burst = $urandom_range(0, 2) == 0;
      gap = busy_burst ? 0 : $urandom_range(0, 19);
      if (n < dir_in.size()) m = dir_in[n];
      else m = rand_matrix();
      if (gap > 0) begin
        @(negedge clk_i);
        in_valid_i <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
      @(negedge clk_i);
      in_valid_i <= 1'b1;
      in_data_i <= m;
      do @(posedge clk_i); while (!in_ready_o);
      if (n < dir_in.size() && dir_typed[n]) inverse_q.push_back(dir_exp[n]);
      else inverse_q.push_back(invert_matrix(m));
    end
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    feeding_done = 1'b1;
  end

  // Takes results with random back-pressure and checks each one.
  initial begin
    int stall;
    bit free_run;
    mi3_out_t exp_r;
    free_run = 1'b0;
    @(posedge rst_ni);
    for (int n = 0; ; n++) begin
      if (n % 120 == 0) free_run = $urandom_range(0, 2) == 0;
      stall = free_run ? 0 : $urandom_range(0, 19);
      if (stall > 0) begin
        @(negedge clk_i);
        out_ready_i <= 1'b0;
        repeat (stall - 1) @(negedge clk_i);
      end
      @(negedge clk_i);
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      if (inverse_q.size() == 0) begin
        $error("result with no matrix outstanding");
        errors++;
      end else begin
        exp_r = inverse_q.pop_front();
        check_field("inv11", exp_r.inv11, out_data_o.inv11);
        check_field("inv12", exp_r.inv12, out_data_o.inv12);
        check_field("inv13", exp_r.inv13, out_data_o.inv13);
        check_field("inv21", exp_r.inv21, out_data_o.inv21);
        check_field("inv22", exp_r.inv22, out_data_o.inv22);
        check_field("inv23", exp_r.inv23, out_data_o.inv23);
        check_field("inv31", exp_r.inv31, out_data_o.inv31);
        check_field("inv32", exp_r.inv32, out_data_o.inv32);
        check_field("inv33", exp_r.inv33, out_data_o.inv33);
        check_field("singular", 32'(exp_r.singular), 32'(out_data_o.singular));
      end
    end
  end

  initial begin
    wait (feeding_done);
    while (inverse_q.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 20) @(posedge clk_i);
    if (errors == 0 && inverse_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
